### hdl/ulcd_pkg.sv
// Shared types, constants and decode functions for the static LCD segment driver.
// No dependencies; every other file of the block except ulcd_if imports this package.
`default_nettype none
package ulcd_pkg;

	localparam int FRAME_CHARS = 6;
	localparam int FILL_W      = $clog2(FRAME_CHARS + 1);
	localparam int IDX_W       = $clog2(FRAME_CHARS);
	localparam int SYM_W       = 5;
	localparam int TABLE_SIZE  = 21;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// request kinds handed from front to back
	localparam logic [1:0] KIND_HOLD = 2'd0;  // byte stored, pins unchanged
	localparam logic [1:0] KIND_END  = 2'd1;  // frame end, decode and load
	localparam logic [1:0] KIND_TICK = 2'd2;  // frame tick, invert pins

	localparam logic [0:0] OP_BYTE = 1'b0;
	localparam logic [0:0] OP_TICK = 1'b1;

	localparam logic [SYM_W-1:0] SYM_UNKNOWN = 5'd1;

	localparam logic [7:0] PIN_WORD0_RST = 8'h7D;
	localparam logic [7:0] PIN_WORD1_RST = 8'hFF;
	localparam logic [7:0] PIN_WORD2_RST = 8'h6D;
	localparam logic [7:0] PIN_WORD3_RST = 8'h5B;
	localparam logic [7:0] PIN_BLANK     = 8'hFF;

	localparam logic [7:0] SEG_TABLE [TABLE_SIZE] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'hFF, 8'h6F,
		8'h58, 8'h38, 8'h5C, 8'h78, 8'h5E, 8'h1C, 8'h73, 8'h40, 8'hF7, 8'hD4, 8'h50
	};

	typedef struct packed {
		logic             stop;
		logic [SYM_W-1:0] sym;
	} dec_t;

	typedef struct packed {
		logic [1:0]                   kind;
		dec_t [FRAME_CHARS-1:0]       dec;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

	function automatic dec_t decode_char(input logic [7:0] c);
		dec_t d;
		d.stop = 1'b0;
		d.sym  = SYM_UNKNOWN;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.sym = SYM_W'(c - 8'h30);
		end else begin
			unique case (c)
				8'h63: d.sym = 5'd10;  // c
				8'h4C: d.sym = 5'd11;  // L
				8'h6F: d.sym = 5'd12;  // o
				8'h74: d.sym = 5'd13;  // t
				8'h64: d.sym = 5'd14;  // d
				8'h75: d.sym = 5'd15;  // u
				8'h70: d.sym = 5'd16;  // p
				8'h2D: d.sym = 5'd17;  // -
				8'h73: d.sym = 5'd5;   // s
				8'h2E: d.sym = 5'd1;   // .
				8'h2C: d.sym = 5'd0;   // ,
				8'h3A: d.sym = 5'd1;   // :
				8'h3B: d.sym = 5'd0;   // ;
				8'h61: d.sym = 5'd18;  // a
				8'h6D: d.sym = 5'd19;  // m
				8'h72: d.sym = 5'd20;  // r
				8'h78: d.stop = 1'b1;  // x blanks the display
				default: d.sym = SYM_UNKNOWN;
			endcase
		end
		return d;
	endfunction

	function automatic logic [7:0] pattern(input logic [SYM_W-1:0] sym);
		logic [7:0] p;
		if (32'(sym) < TABLE_SIZE) p = SEG_TABLE[sym];
		else p = SEG_TABLE[1];
		return p;
	endfunction

endpackage
`default_nettype wire

### hdl/ulcd_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on nothing; payload fields follow the block's item layout.
`default_nettype none
interface ulcd_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface ulcd_out_if;
	logic       valid;
	logic       ready;
	logic       backplane;
	logic [7:0] seg_word0;
	logic [7:0] seg_word1;
	logic [7:0] seg_word2;
	logic [7:0] seg_word3;
	logic       extra_seg_a;
	logic       extra_seg_b;
	logic       sleep_request;

	modport source (output valid, output backplane, output seg_word0, output seg_word1,
		output seg_word2, output seg_word3, output extra_seg_a, output extra_seg_b,
		output sleep_request, input ready);
	modport sink   (input valid, input backplane, input seg_word0, input seg_word1,
		input seg_word2, input seg_word3, input extra_seg_a, input extra_seg_b,
		input sleep_request, output ready);
endinterface
`default_nettype wire

### hdl/ulcd_front.sv
// Front end: accepts requests, buffers frame characters and classifies each request.
// Depends on ulcd_pkg and ulcd_in_if.
`default_nettype none
module ulcd_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	ulcd_in_if.sink           in_ch,
	input  wire logic         q_full,
	output logic              push,
	output ulcd_pkg::cmd_t    push_cmd
);
	import ulcd_pkg::*;

	logic [7:0]        char_q [FRAME_CHARS];
	logic [FILL_W-1:0] fill_q;
	logic              store;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	assign store = (in_ch.operation == OP_BYTE) && (in_ch.rx_byte != 8'h00)
		&& (32'(fill_q) < FRAME_CHARS);

	always_comb begin
		if (in_ch.operation == OP_TICK) push_cmd.kind = KIND_TICK;
		else if (store) push_cmd.kind = KIND_HOLD;
		else push_cmd.kind = KIND_END;
		for (int i = 0; i < FRAME_CHARS; i++) begin
			push_cmd.dec[i] = decode_char(char_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < FRAME_CHARS; i++) char_q[i] <= 8'h00;
		end else if (push) begin
			if (store) begin
				char_q[fill_q[IDX_W-1:0]] <= in_ch.rx_byte;
				fill_q <= fill_q + FILL_W'(1);
			end else if (in_ch.operation == OP_BYTE) begin
				fill_q <= '0;
			end
		end
	end
endmodule
`default_nettype wire

### hdl/ulcd_queue.sv
// Two-entry request queue between front and back end.
// Depends on ulcd_pkg.
`default_nettype none
module ulcd_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire ulcd_pkg::cmd_t push_cmd,
	output logic              full,
	input  wire logic         pop,
	output ulcd_pkg::qhead_t  head
);
	import ulcd_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign full       = (32'(cnt_q) == QUEUE_DEPTH);
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (do_pop) rd_q <= rd_q + QPTR_W'(1);
			if (push && !do_pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end
endmodule
`default_nettype wire

### hdl/ulcd_back.sv
// Back end: applies queued requests to the symbol and pin state, drives the result register.
// Depends on ulcd_pkg and ulcd_out_if.
`default_nettype none
module ulcd_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ulcd_pkg::qhead_t head,
	output logic              pop,
	ulcd_out_if.source        out_ch
);
	import ulcd_pkg::*;

	logic [SYM_W-1:0] sym_q [FRAME_CHARS];
	logic [SYM_W-1:0] sym_n [FRAME_CHARS];
	logic             stop_q, discard_q, valid_q, sleep_q;
	logic [7:0]       w0_q, w1_q, w2_q, w3_q;
	logic [2:0]       com_q;
	logic             stop_n;
	logic [7:0]       t0, t1, t2, t3;

	assign pop = head.valid && (!valid_q || out_ch.ready);

	// frame-end decode: merge new symbols, 'x' positions keep the old one
	always_comb begin
		stop_n = stop_q;
		for (int i = 0; i < FRAME_CHARS; i++) begin
			if (head.cmd.dec[i].stop) begin
				sym_n[i] = sym_q[i];
				stop_n   = 1'b1;
			end else begin
				sym_n[i] = head.cmd.dec[i].sym;
			end
		end
		t0 = pattern(sym_n[0]);
		t1 = pattern(sym_n[1]);
		t2 = pattern(sym_n[2]);
		t3 = pattern(sym_n[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			sleep_q   <= 1'b0;
			stop_q    <= 1'b0;
			discard_q <= 1'b0;
			w0_q      <= PIN_WORD0_RST;
			w1_q      <= PIN_WORD1_RST;
			w2_q      <= PIN_WORD2_RST;
			w3_q      <= PIN_WORD3_RST;
			com_q     <= 3'b000;
			for (int i = 0; i < FRAME_CHARS; i++) sym_q[i] <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				sleep_q <= 1'b0;
				unique case (head.cmd.kind)
					KIND_END: begin
						if (discard_q) begin
							discard_q <= 1'b0;
						end else begin
							for (int i = 0; i < FRAME_CHARS; i++) sym_q[i] <= sym_n[i];
							stop_q <= stop_n;
							if (stop_n) begin
								w0_q  <= PIN_BLANK;
								w1_q  <= PIN_BLANK;
								w2_q  <= PIN_BLANK;
								w3_q  <= PIN_BLANK;
								com_q <= 3'b111;
							end else begin
								w0_q  <= {t3[6], t0[6:0]};
								w1_q  <= {t2[6], t1[6:0]};
								w2_q  <= t2;
								w3_q  <= t3;
								com_q <= {sym_n[5][0], sym_n[4][0], 1'b0};
							end
						end
					end
					KIND_TICK: begin
						w0_q  <= ~w0_q;
						w1_q  <= ~w1_q;
						w2_q  <= ~w2_q;
						w3_q  <= ~w3_q;
						com_q <= ~com_q;
						if (stop_q) begin
							stop_q    <= 1'b0;
							discard_q <= 1'b1;
							sleep_q   <= 1'b1;
						end
					end
					KIND_HOLD: ;
					default: ;
				endcase
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.backplane     = com_q[0];
	assign out_ch.extra_seg_a   = com_q[1];
	assign out_ch.extra_seg_b   = com_q[2];
	assign out_ch.seg_word0     = w0_q;
	assign out_ch.seg_word1     = w1_q;
	assign out_ch.seg_word2     = w2_q;
	assign out_ch.seg_word3     = w3_q;
	assign out_ch.sleep_request = sleep_q;
endmodule
`default_nettype wire

### hdl/uart_static_lcd_segment_driver.sv
// Top level of the static LCD seven-segment driver fed by received serial bytes.
// Depends on ulcd_pkg, ulcd_if, ulcd_front, ulcd_queue and ulcd_back.
//
// Usage:
//   in_ch  : requests. operation 0 carries a received byte in rx_byte,
//            operation 1 is a display frame tick (rx_byte ignored).
//   out_ch : one result per request, the pin levels after that request
//            plus sleep_request, which is 1 only on the tick that ends a
//            blanked display.
// A frame is up to six characters closed by a zero byte or by a seventh
// byte (not stored); at frame end (bar the first after a sleep tick) the
// buffer is decoded and the segment ports are loaded. Ticks invert every
// pin for AC drive. Timing: an accepted request enters the request queue,
// then the back end pops, decodes and registers it as the result; one
// request per cycle is sustained while out_ch.ready is high.
// Reset: pins return to their power-up pattern, the character buffer and
// symbols clear, no result is pending.
// Stall: while a result waits and out_ch.ready is low the result register
// holds; the queue absorbs up to two more requests before in_ch.ready drops.
`default_nettype none
module uart_static_lcd_segment_driver (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ulcd_in_if.sink    in_ch,
	ulcd_out_if.source out_ch
);
	import ulcd_pkg::*;

	logic   push;
	cmd_t   push_cmd;
	logic   q_full;
	logic   pop;
	qhead_t head;

	// front: character buffer and request classification
	ulcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// short queue decoupling the two halves
	ulcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	// back: symbol/pin state and result register
	ulcd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);
endmodule
`default_nettype wire
